/* rtl/core/twdfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdfs_pkg
// Shared types and constants for the two-wire display frame sender.
// ----------------------------------------------------------------------------
package twdfs_pkg;

    localparam int HOLD_CTR_WIDTH_DEF = 16;
    localparam int HOLD_TICKS_WIDTH   = 16;
    localparam logic [HOLD_TICKS_WIDTH-1:0] HOLD_TICKS_RESET = 16'd250;

    localparam int IN_TDATA_WIDTH  = 24;
    localparam int IN_TUSER_WIDTH  = 2;
    localparam int OUT_TDATA_WIDTH = 8;

    localparam logic [1:0] CMD_ONE_BYTE = 2'd1;
    localparam logic [1:0] CMD_TWO_BYTE = 2'd2;

    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_S0       = 5'd1,
        PH_S1       = 5'd2,
        PH_S2       = 5'd3,
        PH_BIT_LO   = 5'd4,
        PH_BIT_HI   = 5'd5,
        PH_ACK_REL  = 5'd6,
        PH_ACK_WAIT = 5'd7,
        PH_ACK_END  = 5'd8,
        PH_P0       = 5'd9,
        PH_P1       = 5'd10,
        PH_P2       = 5'd11,
        PH_P3       = 5'd12,
        PH_P4       = 5'd13,
        PH_P5       = 5'd14
    } t_phase;

    typedef struct packed {
        logic frame_done;
        logic ack_waiting;
        logic busy_res;
        logic dio_level;
        logic clk_level;
    } t_result;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       dio_in;
    } t_item;

endpackage
`default_nettype wire

/* rtl/core/twdfs_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdfs_seq
// Pin-level sequencer: start, LSB-first bytes with acknowledge wait, stop.
// One tick is processed per step; result reflects levels after the tick.
// ----------------------------------------------------------------------------
module twdfs_seq
    import twdfs_pkg::*;
#(
    parameter int HOLD_COUNTER_WIDTH = HOLD_CTR_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire t_item                         i_item,
    input  wire logic [HOLD_COUNTER_WIDTH-1:0] i_hold_limit,
    output t_result                            o_result
);

    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_bit, n_bit;
    logic                          r_byte, n_byte;
    logic                          r_two, n_two;
    logic [7:0]                    r_shift, n_shift;
    logic [7:0]                    r_held, n_held;
    logic [HOLD_COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic                          r_clk_lvl, n_clk_lvl;
    logic                          r_dio_lvl, n_dio_lvl;

    logic   go;
    t_phase tgt;
    logic   done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= '0;
            r_byte    <= 1'b0;
            r_two     <= 1'b0;
            r_shift   <= '0;
            r_held    <= '0;
            r_cnt     <= '0;
            r_clk_lvl <= 1'b1;
            r_dio_lvl <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_two     <= n_two;
            r_shift   <= n_shift;
            r_held    <= n_held;
            r_cnt     <= n_cnt;
            r_clk_lvl <= n_clk_lvl;
            r_dio_lvl <= n_dio_lvl;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_two     = r_two;
        n_shift   = r_shift;
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_clk_lvl = r_clk_lvl;
        n_dio_lvl = r_dio_lvl;
        go        = 1'b0;
        tgt       = PH_IDLE;
        done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_item.command == CMD_ONE_BYTE || i_item.command == CMD_TWO_BYTE) begin
                n_two   = (i_item.command == CMD_TWO_BYTE);
                n_shift = i_item.first_byte;
                n_held  = i_item.second_byte;
                n_bit   = '0;
                n_byte  = 1'b0;
                go      = 1'b1;
                tgt     = PH_S0;
            end
        end else if (r_phase == PH_ACK_WAIT) begin
            if (!i_item.dio_in) begin
                go  = 1'b1;
                tgt = PH_ACK_END;
            end
        end else if (r_cnt < i_hold_limit) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            unique case (r_phase)
                PH_S2: begin
                    go  = 1'b1;
                    tgt = PH_BIT_LO;
                end
                PH_BIT_HI: begin
                    go = 1'b1;
                    if (r_bit >= BIT_LAST) begin
                        tgt = PH_ACK_REL;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_shift = {1'b0, r_shift[7:1]};
                        tgt     = PH_BIT_LO;
                    end
                end
                PH_ACK_REL: begin
                    n_phase = PH_ACK_WAIT;
                    n_cnt   = '0;
                    if (!i_item.dio_in) begin
                        go  = 1'b1;
                        tgt = PH_ACK_END;
                    end
                end
                PH_ACK_END: begin
                    go = 1'b1;
                    if (!r_byte && r_two) begin
                        n_byte  = 1'b1;
                        n_bit   = '0;
                        n_shift = r_held;
                        tgt     = PH_BIT_LO;
                    end else begin
                        tgt = PH_P0;
                    end
                end
                PH_P5: begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                    done    = 1'b1;
                end
                default: begin
                    go  = 1'b1;
                    tgt = t_phase'(r_phase + 5'd1);
                end
            endcase
        end

        if (go) begin
            n_phase = tgt;
            n_cnt   = {{(HOLD_COUNTER_WIDTH-1){1'b0}}, 1'b1};
            unique case (tgt)
                PH_S0:      n_dio_lvl = 1'b1;
                PH_S1:      n_clk_lvl = 1'b1;
                PH_S2:      n_dio_lvl = 1'b0;
                PH_BIT_LO: begin
                    n_clk_lvl = 1'b0;
                    n_dio_lvl = n_shift[0];
                end
                PH_BIT_HI:  n_clk_lvl = 1'b1;
                PH_ACK_REL: begin
                    n_dio_lvl = 1'b1;
                    n_clk_lvl = 1'b0;
                end
                PH_ACK_END: begin
                    n_dio_lvl = 1'b0;
                    n_clk_lvl = 1'b1;
                end
                PH_P0:      n_clk_lvl = 1'b0;
                PH_P1:      n_clk_lvl = 1'b1;
                PH_P2:      n_clk_lvl = 1'b0;
                PH_P3:      n_dio_lvl = 1'b0;
                PH_P4:      n_clk_lvl = 1'b1;
                PH_P5:      n_dio_lvl = 1'b1;
                default: begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    assign o_result.clk_level   = n_clk_lvl;
    assign o_result.dio_level   = n_dio_lvl;
    assign o_result.busy_res    = (n_phase != PH_IDLE);
    assign o_result.ack_waiting = (n_phase == PH_ACK_WAIT);
    assign o_result.frame_done  = done;

endmodule
`default_nettype wire

/* rtl/core/two_wire_display_frame_sender.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_display_frame_sender
// Two-wire start/stop serial writer; one stream transaction per pin tick.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready | tdata: bytes + dio_in, tuser: command
//  m       | out | o_m_tvalid/i_m_tready | tdata: pin levels and status
//  cfg     | in  | i_cfg_we           | i_cfg_wdata: hold_ticks
//
// One transaction per cycle while m does not stall; an item passes the input
// register, then the sequencer step into the result register. The result
// register frees each cycle its contents are taken, so stalls on m back up into
// s only while both registers are full. Synchronous reset puts the lines idle
// high and hold_ticks to 250.
// ----------------------------------------------------------------------------
module two_wire_display_frame_sender
    import twdfs_pkg::*;
#(
    parameter int HOLD_COUNTER_WIDTH = HOLD_CTR_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] first_byte, [15:8] second_byte, [16] dio_in, [23:17] zero
    input  wire logic [IN_TDATA_WIDTH-1:0]   i_s_tdata,
    // [1:0] command
    input  wire logic [IN_TUSER_WIDTH-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [0] clk_level, [1] dio_level, [2] busy_res, [3] ack_waiting,
    // [4] frame_done, [7:5] zero
    output logic [OUT_TDATA_WIDTH-1:0]       o_m_tdata,
    input  wire logic                        i_cfg_we,
    input  wire logic [HOLD_TICKS_WIDTH-1:0] i_cfg_wdata
);

    localparam logic [32:0] CTR_MAX = (33'd1 << HOLD_COUNTER_WIDTH) - 33'd1;

    function automatic logic [HOLD_COUNTER_WIDTH-1:0] limit_of(
        input logic [HOLD_TICKS_WIDTH-1:0] h
    );
        logic [32:0] v;
        v = {{(33-HOLD_TICKS_WIDTH){1'b0}}, h};
        if (v == 33'd0) v = 33'd1;
        if (v > CTR_MAX) v = CTR_MAX;
        return v[HOLD_COUNTER_WIDTH-1:0];
    endfunction

    logic [HOLD_COUNTER_WIDTH-1:0] r_hold_limit;
    logic                          r_in_valid;
    t_item                         r_in_item;
    logic                          r_out_valid;
    t_result                       r_out;
    t_result                       seq_result;
    logic                          advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit <= limit_of(HOLD_TICKS_RESET);
        end else if (i_cfg_we) begin
            r_hold_limit <= limit_of(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.command     <= i_s_tuser[1:0];
            r_in_item.first_byte  <= i_s_tdata[7:0];
            r_in_item.second_byte <= i_s_tdata[15:8];
            r_in_item.dio_in      <= i_s_tdata[16];
        end
    end

    twdfs_seq #(
        .HOLD_COUNTER_WIDTH(HOLD_COUNTER_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .i_hold_limit(r_hold_limit),
        .o_result    (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.frame_done, r_out.ack_waiting,
                         r_out.busy_res, r_out.dio_level, r_out.clk_level};

    a_ack_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ack_waiting |-> r_out.busy_res)
        else $error("ack wait reported outside a frame");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |-> !r_out.busy_res && r_out.dio_level
            && r_out.clk_level)
        else $error("frame end without idle lines");

    a_ack_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ack_waiting |-> !r_out.clk_level && r_out.dio_level)
        else $error("lines not released during ack wait");

    a_limit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_hold_limit != '0)
        else $error("hold limit zero");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the two-wire display frame sender. Every transaction
// on the input side is one pin tick; a behavioral copy of the pin sequencer
// predicts the pin levels and status bits of the result for each tick. A
// short stimulus table covers reset levels, the unused command code, frame
// starts and requests while busy. Random phases then follow at several short
// hold settings, zero included, with random acknowledge delays, bursty input
// and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
    import twdfs_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_TICKS = 60;

    localparam t_result LINES_IDLE  = '{frame_done: 1'b0, ack_waiting: 1'b0,
                                        busy_res: 1'b0, dio_level: 1'b1,
                                        clk_level: 1'b1};
    localparam t_result FRAME_START = '{frame_done: 1'b0, ack_waiting: 1'b0,
                                        busy_res: 1'b1, dio_level: 1'b1,
                                        clk_level: 1'b1};
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        bit         wr_cfg;
        logic [15:0] cfg_val;
        logic [1:0] cmd;
        logic [7:0] b_first;
        logic [7:0] b_second;
        logic       dio;
        bit         typed;
        t_result    exp;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_TDATA_WIDTH-1:0] s_tdata = '0;
    logic [IN_TUSER_WIDTH-1:0] s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [HOLD_TICKS_WIDTH-1:0] cfg_wdata = '0;

    // sequencer copy
    t_phase      ph = PH_IDLE;
    logic [2:0]  bit_idx = '0;
    logic        byte_idx = 1'b0;
    logic        two_byte = 1'b0;
    logic [7:0]  shift_b = '0;
    logic [7:0]  held_b = '0;
    int unsigned hold_ctr = 0;
    logic        clk_q = 1'b1;
    logic        dio_q = 1'b1;
    logic [15:0] hold_cfg = HOLD_TICKS_RESET;

    t_result     pin_levels_q[$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int          ack_pct = 50;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          rx_tick = 0;
    t_row        dir_rows[10];

    always #6 clk = ~clk;

    two_wire_display_frame_sender uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    function automatic void go_phase(t_phase p);
        ph = p;
        hold_ctr = 1;
        case (p)
            PH_S0:      dio_q = 1'b1;
            PH_S1:      clk_q = 1'b1;
            PH_S2:      dio_q = 1'b0;
            PH_BIT_LO: begin
                clk_q = 1'b0;
                dio_q = shift_b[0];
            end
            PH_BIT_HI:  clk_q = 1'b1;
            PH_ACK_REL: begin
                dio_q = 1'b1;
                clk_q = 1'b0;
            end
            PH_ACK_END: begin
                dio_q = 1'b0;
                clk_q = 1'b1;
            end
            PH_P0:      clk_q = 1'b0;
            PH_P1:      clk_q = 1'b1;
            PH_P2:      clk_q = 1'b0;
            PH_P3:      dio_q = 1'b0;
            PH_P4:      clk_q = 1'b1;
            PH_P5:      dio_q = 1'b1;
            default:    hold_ctr = 0;
        endcase
    endfunction

    function automatic t_result pin_tick(t_item it);
        t_result     r;
        logic        done;
        int unsigned lim;
        done = 1'b0;
        lim = (hold_cfg == 0) ? 1 : hold_cfg;
        if (ph == PH_IDLE) begin
            if (it.command == CMD_ONE_BYTE || it.command == CMD_TWO_BYTE) begin
                two_byte = (it.command == CMD_TWO_BYTE);
                shift_b = it.first_byte;
                held_b = it.second_byte;
                bit_idx = '0;
                byte_idx = 1'b0;
                go_phase(PH_S0);
            end
        end else if (ph == PH_ACK_WAIT) begin
            if (!it.dio_in) go_phase(PH_ACK_END);
        end else if (hold_ctr < lim) begin
            hold_ctr++;
        end else begin
            case (ph)
                PH_S2: go_phase(PH_BIT_LO);
                PH_BIT_HI: begin
                    if (bit_idx == BIT_LAST) begin
                        go_phase(PH_ACK_REL);
                    end else begin
                        bit_idx++;
                        shift_b = shift_b >> 1;
                        go_phase(PH_BIT_LO);
                    end
                end
                PH_ACK_REL: begin
                    ph = PH_ACK_WAIT;
                    hold_ctr = 0;
                    if (!it.dio_in) go_phase(PH_ACK_END);
                end
                PH_ACK_END: begin
                    if (!byte_idx && two_byte) begin
                        byte_idx = 1'b1;
                        bit_idx = '0;
                        shift_b = held_b;
                        go_phase(PH_BIT_LO);
                    end else begin
                        go_phase(PH_P0);
                    end
                end
                PH_P5: begin
                    ph = PH_IDLE;
                    hold_ctr = 0;
                    done = 1'b1;
                end
                default: go_phase(t_phase'(ph + 5'd1));
            endcase
        end
        r.clk_level = clk_q;
        r.dio_level = dio_q;
        r.busy_res = (ph != PH_IDLE);
        r.ack_waiting = (ph == PH_ACK_WAIT);
        r.frame_done = done;
        return r;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) it.command = CMD_TICK;
        else if (pick < 65) it.command = CMD_ONE_BYTE;
        else if (pick < 92) it.command = CMD_TWO_BYTE;
        else it.command = CMD_UNUSED;
        it.first_byte = 8'($urandom_range(0, 255));
        it.second_byte = 8'($urandom_range(0, 255));
        it.dio_in = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_result exp);
        int      gap;
        t_result p;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, it.dio_in, it.second_byte, it.first_byte};
        s_tuser <= it.command;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        p = pin_tick(it);
        pin_levels_q.push_back(typed ? exp : p);
    endtask

    task automatic drain_frame();
        while (ph != PH_IDLE) send_item(rand_item(), 1'b0, LINES_IDLE);
    endtask

    task automatic write_hold(input logic [15:0] v);
        drain_frame();
        s_tvalid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_cfg = v;
        burst_left = 0;
    endtask

    always @(posedge clk) begin
        t_result act;
        act = t_result'(m_tdata[4:0]);
        if (rst_n && m_tvalid && m_tready) begin
            if (pin_levels_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected result %b", m_tdata);
                mismatches++;
            end else if (act !== pin_levels_q[0] || m_tdata[7:5] !== 3'b000) begin
                if (mismatches < 10) begin
                    $display("mismatch: expected %b got %b (pad %b)",
                             pin_levels_q[0], act, m_tdata[7:5]);
                end
                mismatches++;
                void'(pin_levels_q.pop_front());
            end else begin
                void'(pin_levels_q.pop_front());
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= (rx_tick % 5) >= 2;
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rx_tick % 11) == 0;
        endcase
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_item it;
        int    holds[7];
        holds = '{1, 2, 3, 0, 4, 1, 2};
        dir_rows = '{
            '{1'b0, 16'd0, CMD_TICK,     8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE},
            '{1'b0, 16'd0, CMD_UNUSED,   8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE},
            '{1'b0, 16'd0, CMD_UNUSED,   8'h00, 8'h00, 1'b0, 1'b1, LINES_IDLE},
            '{1'b1, 16'd3, CMD_TWO_BYTE, 8'h00, 8'hFF, 1'b0, 1'b1, FRAME_START},
            '{1'b0, 16'd0, CMD_ONE_BYTE, 8'hFF, 8'h00, 1'b0, 1'b0, LINES_IDLE},
            '{1'b0, 16'd0, CMD_TWO_BYTE, 8'hA5, 8'h5A, 1'b1, 1'b0, LINES_IDLE},
            '{1'b1, 16'd0, CMD_ONE_BYTE, 8'hFF, 8'h00, 1'b1, 1'b1, FRAME_START},
            '{1'b0, 16'd0, CMD_TICK,     8'h00, 8'h00, 1'b1, 1'b0, LINES_IDLE},
            '{1'b1, 16'd1, CMD_TWO_BYTE, 8'h80, 8'h01, 1'b0, 1'b1, FRAME_START},
            '{1'b0, 16'd0, CMD_TWO_BYTE, 8'h7F, 8'hFE, 1'b0, 1'b0, LINES_IDLE}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr_cfg) write_hold(dir_rows[i].cfg_val);
            it.command = dir_rows[i].cmd;
            it.first_byte = dir_rows[i].b_first;
            it.second_byte = dir_rows[i].b_second;
            it.dio_in = dir_rows[i].dio;
            send_item(it, dir_rows[i].typed, dir_rows[i].exp);
        end

        foreach (holds[i]) begin
            write_hold(16'(holds[i]));
            ack_pct = $urandom_range(15, 95);
            repeat (PHASE_TICKS) send_item(rand_item(), 1'b0, LINES_IDLE);
        end

        s_tvalid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
